### src/eik_pkg.sv
// shared widths, types and helper functions for the upwind eikonal update core
package eik_pkg;

   localparam int VAL_W           = 32;
   localparam int NUM_NEIGHBORS   = 4;
   localparam int MAG_W           = 32;
   localparam int H_W             = 31;
   localparam int OUT_W           = 31;
   localparam int BASE_W          = 33;
   localparam int SQ_W            = 62;
   localparam int RAD_W           = 64;
   localparam int ROOT_W          = RAD_W / 2;
   localparam int REM_W           = ROOT_W + 4;
   localparam int STEPS_PER_STAGE = 2;
   localparam int SQRT_STAGES     = ROOT_W / STEPS_PER_STAGE;
   localparam int IN_DATA_W       = NUM_NEIGHBORS * VAL_W;
   localparam int OUT_DATA_W      = ((OUT_W + 7) / 8) * 8;

   localparam logic [H_W-1:0]   H_RESET = H_W'(65536);
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   typedef struct packed {
      logic              use_root;
      logic [BASE_W-1:0] base;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_acc_type;

   function automatic logic [MAG_W-1:0] magnitude(input logic [VAL_W-1:0] v);
      logic [VAL_W-1:0] neg;
      neg = ~v + 1'b1;
      return v[VAL_W-1] ? neg : v;
   endfunction

   // one restoring square root digit
   function automatic sqrt_acc_type sqrt_step(input sqrt_acc_type acc,
                                              input logic [1:0] pair);
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      sqrt_acc_type     r;
      rem_sh = {acc.rem[REM_W-3:0], pair};
      trial  = {2'b00, acc.root, 2'b01};
      if (rem_sh >= trial) begin
         r.rem  = rem_sh - trial;
         r.root = {acc.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = rem_sh;
         r.root = {acc.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

### src/eik_sort.sv
// magnitude and two-way sort stages of the neighbor distances
module eik_sort import eik_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [IN_DATA_W-1:0] in_data,
   output logic                 out_valid,
   output logic [MAG_W-1:0]     out_d0,
   output logic [MAG_W-1:0]     out_d1
);

   logic             mag_valid_ff;
   logic [MAG_W-1:0] mag_ff [NUM_NEIGHBORS];
   logic             sort_valid_ff;
   logic [MAG_W-1:0] d0_ff;
   logic [MAG_W-1:0] d1_ff;
   logic [MAG_W-1:0] a_in;
   logic [MAG_W-1:0] b_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff  <= 1'b0;
         sort_valid_ff <= 1'b0;
      end else if (advance) begin
         mag_valid_ff  <= in_valid;
         sort_valid_ff <= mag_valid_ff;
      end
   end

   for (genvar i = 0; i < NUM_NEIGHBORS; i++) begin : g_mag
      always_ff @(posedge clock) begin
         if (advance) begin
            mag_ff[i] <= magnitude(in_data[i*VAL_W +: VAL_W]);
         end
      end
   end

   // left/right then down/up
   assign a_in = (mag_ff[0] < mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign b_in = (mag_ff[2] < mag_ff[3]) ? mag_ff[2] : mag_ff[3];

   always_ff @(posedge clock) begin
      if (advance) begin
         d0_ff <= (a_in < b_in) ? a_in : b_in;
         d1_ff <= (a_in < b_in) ? b_in : a_in;
      end
   end

   assign out_valid = sort_valid_ff;
   assign out_d0    = d0_ff;
   assign out_d1    = d1_ff;

endmodule

### src/eik_radicand.sv
// branch decision, squares and radicand stages
module eik_radicand import eik_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [MAG_W-1:0] in_d0,
   input  logic [MAG_W-1:0] in_d1,
   input  logic [H_W-1:0]   spacing,
   output logic             out_valid,
   output logic [RAD_W-1:0] out_rad,
   output side_type         out_side
);

   logic [BASE_W-1:0] sum_dh;
   logic [BASE_W-1:0] sum_dd;
   logic              direct_in;
   logic [MAG_W-1:0]  diff;
   logic [H_W-1:0]    diff_lo;

   logic              sq_valid_ff;
   side_type          sq_side_ff;
   logic [SQ_W-1:0]   h_sq_ff;
   logic [SQ_W-1:0]   diff_sq_ff;

   logic              rad_valid_ff;
   side_type          rad_side_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [SQ_W:0]     rad_in;

   assign sum_dh    = {1'b0, in_d0} + BASE_W'(spacing);
   assign sum_dd    = {1'b0, in_d0} + {1'b0, in_d1};
   assign direct_in = (sum_dh <= {1'b0, in_d1});
   assign diff      = in_d1 - in_d0;
   // below the spacing whenever the root is used
   assign diff_lo   = diff[H_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         rad_valid_ff <= 1'b0;
      end else if (advance) begin
         sq_valid_ff  <= in_valid;
         rad_valid_ff <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_side_ff.use_root <= ~direct_in;
         sq_side_ff.base     <= direct_in ? sum_dh : sum_dd;
         h_sq_ff             <= SQ_W'(spacing) * SQ_W'(spacing);
         diff_sq_ff          <= SQ_W'(diff_lo) * SQ_W'(diff_lo);
      end
   end

   assign rad_in = {h_sq_ff, 1'b0} - {1'b0, diff_sq_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_side_ff <= sq_side_ff;
         rad_ff      <= sq_side_ff.use_root ? RAD_W'(rad_in) : '0;
      end
   end

   assign out_valid = rad_valid_ff;
   assign out_rad   = rad_ff;
   assign out_side  = rad_side_ff;

endmodule

### src/eik_sqrt.sv
// pipelined restoring integer square root, a fixed number of digits per stage
module eik_sqrt import eik_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   logic             valid_ff [SQRT_STAGES];
   sqrt_acc_type     acc_ff   [SQRT_STAGES];
   side_type         side_ff  [SQRT_STAGES];
   logic [RAD_W-1:0] rad_ff   [SQRT_STAGES-1];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      logic             v_src;
      sqrt_acc_type     acc_src;
      logic [RAD_W-1:0] rad_src;
      side_type         side_src;
      sqrt_acc_type     acc_in;

      if (s == 0) begin : g_first
         assign v_src    = in_valid;
         assign acc_src  = '0;
         assign rad_src  = in_rad;
         assign side_src = in_side;
      end else begin : g_next
         assign v_src    = valid_ff[s-1];
         assign acc_src  = acc_ff[s-1];
         assign rad_src  = rad_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      always_comb begin
         acc_in = acc_src;
         for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            acc_in = sqrt_step(acc_in, rad_src[RAD_W-1-2*k -: 2]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            acc_ff[s]  <= acc_in;
            side_ff[s] <= side_src;
         end
      end

      if (s < SQRT_STAGES - 1) begin : g_rad
         always_ff @(posedge clock) begin
            if (advance) begin
               rad_ff[s] <= rad_src << (2 * STEPS_PER_STAGE);
            end
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = acc_ff[SQRT_STAGES-1].root;
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

### src/eikonal_upwind_update_2d_core.sv
// top level of the upwind 2d eikonal update core
//
//   port group   direction   word contents (lowest bit up)
//   req_         in          left_value, right_value, down_value, up_value
//   rsp_         out         new_distance, one zero pad bit
//   csr_         in          grid_spacing
//
// one word accepted per cycle while the skid register is empty; the pipeline is two sort
// stages, two multiply/radicand stages, sixteen square root stages at two digits each,
// and one output register
// the whole pipeline holds while the skid register is full; req_tready is
// registered and drops only then
// reset clears all valid bits and sets grid_spacing to 1.0
module eikonal_upwind_update_2d_core import eik_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,   // left_value, right_value, down_value, up_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata,   // new_distance, zero pad
   input  logic                  csr_wr_en,
   input  logic [H_W-1:0]        csr_wr_data
);

   logic              advance;
   logic [H_W-1:0]    h_ff;

   logic              sort_valid;
   logic [MAG_W-1:0]  sort_d0;
   logic [MAG_W-1:0]  sort_d1;
   logic              rad_valid;
   logic [RAD_W-1:0]  rad;
   side_type          rad_side;
   logic              sqrt_valid;
   logic [ROOT_W-1:0] sqrt_root;
   side_type          sqrt_side;

   logic [BASE_W:0]   sum_in;
   logic [BASE_W-1:0] half_in;
   logic [OUT_W-1:0]  result_in;
   logic              fire_out;
   logic              last_valid;

   logic              out_valid_ff;
   logic [OUT_W-1:0]  out_ff;
   logic              skid_full_ff;
   logic [OUT_W-1:0]  skid_ff;

   assign advance = ~skid_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff <= H_RESET;
      end else if (csr_wr_en) begin
         h_ff <= csr_wr_data;
      end
   end

   eik_sort u_sort (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (sort_valid),
      .out_d0    (sort_d0),
      .out_d1    (sort_d1)
   );

   eik_radicand u_radicand (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sort_valid),
      .in_d0     (sort_d0),
      .in_d1     (sort_d1),
      .spacing   (h_ff),
      .out_valid (rad_valid),
      .out_rad   (rad),
      .out_side  (rad_side)
   );

   eik_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (rad_valid),
      .in_rad    (rad),
      .in_side   (rad_side),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root),
      .out_side  (sqrt_side)
   );

   // final halving on the root branch, and saturation
   assign sum_in    = {1'b0, sqrt_side.base} + (BASE_W + 1)'(sqrt_root);
   assign half_in   = sqrt_side.use_root ? sum_in[BASE_W:1] : sqrt_side.base;
   assign result_in = (|half_in[BASE_W-1:OUT_W]) ? OUT_MAX : half_in[OUT_W-1:0];

   assign fire_out   = out_valid_ff & rsp_tready;
   assign last_valid = sqrt_valid & advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (fire_out) begin
            skid_full_ff <= 1'b0;
         end
      end else if (~out_valid_ff | rsp_tready) begin
         out_valid_ff <= last_valid;
      end else if (last_valid) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (fire_out) begin
            out_ff <= skid_ff;
         end
      end else if (~out_valid_ff | rsp_tready) begin
         out_ff <= result_in;
      end else begin
         skid_ff <= result_in;
      end
   end

   assign req_tready = ~skid_full_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_DATA_W'(out_ff);

`ifndef NO_ASSERTIONS
   a_skid_needs_out : assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   a_skid_fill_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(out_valid_ff & ~rsp_tready & sqrt_valid))
      else $error("skid register filled without a stalled output");

   a_skid_holds : assert property (@(posedge clock) disable iff (reset)
      (skid_full_ff & ~rsp_tready) |=> skid_full_ff)
      else $error("skid register drained without a handshake");
`endif

endmodule

### dv/tb_eikonal_upwind_update_2d_core.sv
// self-checking testbench for the upwind 2d eikonal update core
module tb_eikonal_upwind_update_2d_core;
   import eik_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
   localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [H_W-1:0]        csr_wr_data = '0;

   logic [H_W-1:0]   spacing_model = H_RESET;
   logic [OUT_W-1:0] pending_distance[$];
   int               failures = 0;
   int               cycle_count = 0;
   int               burst_left = 0;

   eikonal_upwind_update_2d_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // upwind update for one word of neighbor distances
   function automatic logic [OUT_W-1:0] predict_distance(input logic [IN_DATA_W-1:0] w,
                                                         input logic [H_W-1:0] h);
      logic [VAL_W-1:0] v;
      logic [63:0]      mag[NUM_NEIGHBORS];
      logic [63:0]      a, b, d0, d1, h64, diff, rad, root, trial, sum;
      for (int i = 0; i < NUM_NEIGHBORS; i++) begin
         v = w[i*VAL_W +: VAL_W];
         mag[i] = {32'd0, v[VAL_W-1] ? VAL_W'(-v) : v};
      end
      a   = (mag[0] < mag[1]) ? mag[0] : mag[1];
      b   = (mag[2] < mag[3]) ? mag[2] : mag[3];
      d0  = (a < b) ? a : b;
      d1  = (a < b) ? b : a;
      h64 = {33'd0, h};
      if (d0 + h64 <= d1) begin
         sum = d0 + h64;
      end else begin
         diff = d1 - d0;
         rad  = 2 * h64 * h64 - diff * diff;
         root = '0;
         for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= rad) root = trial;
         end
         sum = (d0 + d1 + root) >> 1;
      end
      return (sum > 64'h7fff_ffff) ? OUT_MAX : sum[OUT_W-1:0];
   endfunction

   function automatic logic [IN_DATA_W-1:0] pack_neighbors(input logic [VAL_W-1:0] left,
                                                           input logic [VAL_W-1:0] right,
                                                           input logic [VAL_W-1:0] down,
                                                           input logic [VAL_W-1:0] up);
      return {up, down, right, left};
   endfunction

   function automatic logic [VAL_W-1:0] with_sign(input logic [63:0] mag);
      return ($urandom_range(0, 1) != 0) ? VAL_W'(-mag[VAL_W-1:0]) : mag[VAL_W-1:0];
   endfunction

   // one neighbor pair whose smaller magnitude is m
   function automatic logic [2*VAL_W-1:0] pair_with_min(input logic [63:0] m);
      logic [63:0] other;
      other = m + $urandom_range(0, 32'h0fff_ffff);
      if (other > 64'h7fff_ffff) other = 64'h7fff_ffff;
      if ($urandom_range(0, 1) != 0) return {with_sign(other), with_sign(m)};
      return {with_sign(m), with_sign(other)};
   endfunction

   function automatic logic [VAL_W-1:0] corner_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 32'd1;
         2: return '1;
         3: return VAL_MAX;
         4: return VAL_MIN;
         default: return VAL_MIN + 1;
      endcase
   endfunction

   function automatic logic [IN_DATA_W-1:0] random_neighbors();
      logic [63:0] hcap, a_mag, b_mag, swap;
      int          pick;
      pick = $urandom_range(0, 99);
      hcap = (spacing_model == 0) ? 64'd65536 :
             (spacing_model > 31'h1000_0000) ? 64'h1000_0000 : {33'd0, spacing_model};
      a_mag = $urandom_range(0, 32'h4000_0000);
      if (pick < 20) begin
         return {$urandom, $urandom, $urandom, $urandom};
      end else if (pick < 35) begin
         return pack_neighbors(corner_value(), corner_value(), corner_value(), corner_value());
      end else if (pick < 50) begin
         // front exactly at, or one lsb around, the one-sided threshold
         if (a_mag + spacing_model + 1 > 64'h7fff_ffff) a_mag = 0;
         b_mag = a_mag + spacing_model + $urandom_range(0, 2);
         b_mag = (b_mag == 0) ? 64'd0 : b_mag - 1;
      end else begin
         b_mag = a_mag + $urandom_range(0, 32'(hcap + hcap / 2));
      end
      if ($urandom_range(0, 1) != 0) begin
         swap  = a_mag;
         a_mag = b_mag;
         b_mag = swap;
      end
      return {pair_with_min(b_mag), pair_with_min(a_mag)};
   endfunction

   task automatic send_neighbors(input logic [IN_DATA_W-1:0] w);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      pending_distance = {pending_distance, predict_distance(w, spacing_model)};
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_distance.size() != 0) @(posedge clock);
   endtask

   task automatic write_spacing(input logic [H_W-1:0] h);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= h;
      @(posedge clock);
      spacing_model = h;
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_neighbors(random_neighbors());
   endtask

   // spacing left at its reset value of 1.0
   task automatic test_reset_spacing_corners();
      send_neighbors(pack_neighbors('0, '0, '0, '0));
      send_neighbors(pack_neighbors(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX));
      send_neighbors(pack_neighbors(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN));
      send_neighbors(pack_neighbors(VAL_MIN, VAL_MAX, 32'd1, '1));
      send_neighbors(pack_neighbors('0, 32'h0003_0000, 32'h0001_0000, VAL_MAX));
      send_neighbors(pack_neighbors('0, 32'h0003_0000, 32'h0001_0001, VAL_MAX));
      send_neighbors(pack_neighbors('0, 32'h0003_0000, 32'h0000_ffff, VAL_MAX));
      send_neighbors(pack_neighbors(32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
                                    32'h0005_0000));
      send_neighbors(pack_neighbors(-32'sh0003_0000, -32'sh0002_0000, -32'sh0002_8000,
                                    32'h0004_0000));
      send_neighbors(pack_neighbors(32'h0009_0000, 32'h000a_0000, 32'h0008_8000,
                                    32'h0009_9999));
      send_neighbors(pack_neighbors(32'h7fff_0000, 32'h0001_2345, -32'sh7fff_0000,
                                    32'h0002_3456));
      send_neighbors(pack_neighbors(32'h7fff_0000, 32'h7fff_8000, 32'h7fff_ffff,
                                    32'h7fff_c000));
      send_neighbors(pack_neighbors(32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333,
                                    32'hcccc_cccc));
      send_random(300);
   endtask

   task automatic test_spacing_extremes();
      write_spacing(31'd1);
      send_neighbors(pack_neighbors('0, '0, '0, '0));
      send_neighbors(pack_neighbors(32'd7, 32'd9, 32'd8, 32'd100));
      send_random(150);
      write_spacing(31'h7fff_ffff);
      send_neighbors(pack_neighbors('0, '0, '0, '0));
      send_neighbors(pack_neighbors(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN));
      send_neighbors(pack_neighbors('0, '0, VAL_MAX, VAL_MAX));
      send_random(150);
   endtask

   task automatic test_zero_spacing();
      write_spacing('0);
      send_neighbors(pack_neighbors(32'h0001_0000, 32'h0002_0000, 32'h0001_0000,
                                    32'h0003_0000));
      send_random(100);
   endtask

   task automatic test_random_spacing();
      repeat (3) begin
         write_spacing(31'($urandom_range(1, 32'h0010_0000)));
         send_random(80);
      end
      write_spacing(31'($urandom_range(1, 32'h7fff_ffff)));
      send_random(60);
      write_spacing(H_RESET);
      send_random(40);
   endtask

   // receiver stall pattern, its mode picked anew at random from four
   int ready_mode = 0;
   always @(posedge clock) begin
      if (cycle_count % 128 == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cycle_count % 8 < 5);
      endcase
   end

   always @(posedge clock) begin
      logic [OUT_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_distance.size() == 0) begin
            $error("new_distance: expected none, actual %0d", rsp_tdata[OUT_W-1:0]);
            failures++;
         end else begin
            want = pending_distance.pop_front();
            if (rsp_tdata[OUT_W-1:0] !== want) begin
               $error("new_distance: expected %0d, actual %0d", want, rsp_tdata[OUT_W-1:0]);
               failures++;
            end
            if (rsp_tdata[OUT_DATA_W-1:OUT_W] !== '0) begin
               $error("pad: expected 0, actual %0d", rsp_tdata[OUT_DATA_W-1:OUT_W]);
               failures++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_spacing_corners();
      test_spacing_extremes();
      test_zero_spacing();
      test_random_spacing();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_distance.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
